>>> rtl/core/bf_pkg.sv
package bf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COLSUM_W   = 18;
	localparam int WSUM_W     = 20;
	localparam int ROW_W      = 12;
	localparam int OCOL_W     = 6;
	localparam int IW_W       = 7;
	localparam int IH_W       = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// window size and frame limits
	localparam int WIN          = 3;
	localparam int MAX_HEIGHT   = 4096;
	localparam int RESET_WIDTH  = 10;
	localparam int RESET_HEIGHT = 10;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COLSUM_W-1:0] colsum_t;
	typedef logic signed [WSUM_W-1:0]   wsum_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

endpackage

>>> rtl/core/bf_line_store.sv
module bf_line_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  bf_pkg::sample_t wr_upper,
	input  bf_pkg::sample_t wr_lower,
	output bf_pkg::sample_t rd_upper_s1,
	output bf_pkg::sample_t rd_lower_s1
);
	import bf_pkg::*;

	sample_t          mem_upper_q [DEPTH];
	sample_t          mem_lower_q [DEPTH];
	logic [DEPTH-1:0] vld_q;

	// both rows of one column are written together
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_upper_q[wr_addr] <= wr_upper;
			mem_lower_q[wr_addr] <= wr_lower;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// write in the same cycle to the same column is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_upper_s1 <= wr_upper;
				rd_lower_s1 <= wr_lower;
			end else if (vld_q[rd_addr]) begin
				rd_upper_s1 <= mem_upper_q[rd_addr];
				rd_lower_s1 <= mem_lower_q[rd_addr];
			end else begin
				rd_upper_s1 <= '0;
				rd_lower_s1 <= '0;
			end
		end
	end

endmodule

>>> rtl/core/bf_col_cell.sv
module bf_col_cell (
	input  logic            clk,
	input  logic            shift_en,
	input  bf_pkg::colsum_t col_in,
	input  bf_pkg::wsum_t   acc_in,
	output bf_pkg::colsum_t col_out,
	output bf_pkg::wsum_t   acc_out
);
	import bf_pkg::*;

	colsum_t col_q;

	// column sum moves one cell on per shift
	always_ff @(posedge clk) begin
		if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;
	assign acc_out = acc_in + wsum_t'(col_q);

endmodule

>>> rtl/core/box_filter_3x3_valid.sv
// 3x3 box filter, valid region only, over a row-major stream of signed q8.8 samples.
// pixel channel: pix_valid / pix_stall carry sample and frame_start, one per transaction.
// frame_start forces the position to row 0, column 0; frames also wrap on their own.
// result channel: sum_valid / sum_stall carry window_sum (sum of nine samples), out_row,
// out_col and last, one result for each sample at row >= 2 and column >= 2.
// config channel: cfg_valid / cfg_ready (always ready), cfg_index selects image_width (0)
// or image_height (1); other indexes are ignored. write only while the block is idle.
// throughput: one sample per cycle when not stalled, set by the single read/write port pair
// of the line stores and the one-column shift of the cell chain.
// path: a sample's result reaches the outputs through the line store read, the cell chain
// and the output register.
// stall: while a result waits with sum_stall high the whole pipeline holds and
// pix_stall is high; otherwise a sample is taken every cycle.
// reset: position to row 0, column 0, image 10 x 10, line store valid bits cleared at
// once so unwritten columns read as zero; no clearing pass.
module box_filter_3x3_valid #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  bf_pkg::sample_t                 sample,
	input  logic                            frame_start,
	output logic                            sum_valid,
	input  logic                            sum_stall,
	output bf_pkg::wsum_t                   window_sum,
	output logic [bf_pkg::ROW_W-1:0]        out_row,
	output logic [bf_pkg::OCOL_W-1:0]       out_col,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bf_pkg::*;

	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int CMP_W      = (CW + 1 > IW_W) ? CW + 1 : IW_W;
	localparam int RST_W_EFF  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

	// config, held as last column / last row of the clamped frame
	logic [CMP_W-1:0] w_last_q;
	logic [ROW_W-1:0] h_last_q;
	logic [CMP_W-1:0] cfg_w_ext;
	logic [CMP_W-1:0] w_eff;
	logic [IH_W-1:0]  h_eff;
	logic             cfg_acc;

	// position of the next sample
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_cur;
	logic [ROW_W-1:0] row_cur;
	logic [CMP_W-1:0] col_cur_ext;
	logic             col_wrap;
	logic             row_wrap;
	logic [CW-1:0]    col_nxt;
	logic [ROW_W-1:0] row_nxt;
	logic             emit_c;
	logic             last_c;
	logic [ROW_W-1:0] orow_c;
	logic [OCOL_W-1:0] ocol_c;

	// pipeline control
	logic pix_acc;
	logic adv;
	logic wr_pend_q;

	// stage 1: line store read data and item info
	logic              v_s1;
	sample_t           sample_s1;
	logic [CW-1:0]     col_s1;
	logic              emit_s1;
	logic              last_s1;
	logic [ROW_W-1:0]  orow_s1;
	logic [OCOL_W-1:0] ocol_s1;
	sample_t           rd_upper_s1;
	sample_t           rd_lower_s1;
	colsum_t           colsum_s1;

	// stage 2: item sits in the first cell
	logic              v_s2;
	logic              emit_s2;
	logic              last_s2;
	logic [ROW_W-1:0]  orow_s2;
	logic [OCOL_W-1:0] ocol_s2;

	// output register
	logic              sum_valid_q;
	wsum_t             window_sum_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [OCOL_W-1:0] out_col_q;
	logic              last_q;

	colsum_t cell_col [WIN];
	wsum_t   cell_acc [WIN+1];
	logic    shift_en;

	// config port, always ready; values are clamped on the way in
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign cfg_w_ext = CMP_W'(cfg_data[IW_W-1:0]);

	always_comb begin
		if (cfg_w_ext < CMP_W'(WIN)) begin
			w_eff = CMP_W'(WIN);
		end else if (cfg_w_ext > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end else begin
			w_eff = cfg_w_ext;
		end
		if (cfg_data < IH_W'(WIN)) begin
			h_eff = IH_W'(WIN);
		end else if (cfg_data > IH_W'(MAX_HEIGHT)) begin
			h_eff = IH_W'(MAX_HEIGHT);
		end else begin
			h_eff = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= CMP_W'(RST_W_EFF - 1);
			h_last_q <= ROW_W'(RESET_HEIGHT - 1);
		end else if (cfg_acc) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  w_last_q <= w_eff - CMP_W'(1);
				REG_IMAGE_HEIGHT: h_last_q <= ROW_W'(h_eff - IH_W'(1));
				default: ;
			endcase
		end
	end

	// pipeline moves unless a result is stuck at the output
	assign adv       = !sum_valid_q || !sum_stall;
	assign pix_stall = !adv;
	assign pix_acc   = pix_valid && !pix_stall;

	// position of the incoming sample and where it goes next
	always_comb begin
		col_cur     = frame_start ? '0 : col_q;
		row_cur     = frame_start ? '0 : row_q;
		col_cur_ext = CMP_W'(col_cur);
		// a count past a shrunken bound wraps too
		col_wrap    = col_cur_ext >= w_last_q;
		row_wrap    = row_cur >= h_last_q;
		col_nxt     = col_wrap ? '0 : col_cur + CW'(1);
		if (!col_wrap) begin
			row_nxt = row_cur;
		end else if (row_wrap) begin
			row_nxt = '0;
		end else begin
			row_nxt = row_cur + ROW_W'(1);
		end
		emit_c = (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));
		last_c = (row_cur == h_last_q) && (col_cur_ext == w_last_q);
		orow_c = row_cur - ROW_W'(2);
		ocol_c = OCOL_W'(col_cur - CW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// line stores: read at acceptance, written back in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_q <= 1'b0;
		end else begin
			wr_pend_q <= pix_acc;
		end
	end

	bf_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (pix_acc),
		.rd_addr     (col_cur),
		.wr_en       (wr_pend_q),
		.wr_addr     (col_s1),
		.wr_upper    (rd_lower_s1),
		.wr_lower    (sample_s1),
		.rd_upper_s1 (rd_upper_s1),
		.rd_lower_s1 (rd_lower_s1)
	);

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			sample_s1 <= sample;
			col_s1    <= col_cur;
			emit_s1   <= emit_c;
			last_s1   <= last_c;
			orow_s1   <= orow_c;
			ocol_s1   <= ocol_c;
		end
	end

	assign colsum_s1 = colsum_t'(rd_upper_s1) + colsum_t'(rd_lower_s1) + colsum_t'(sample_s1);

	// stage 2: the column chain, newest column in the first cell
	assign shift_en    = adv && v_s1;
	assign cell_acc[0] = '0;

	for (genvar k = 0; k < WIN; k++) begin : g_cell
		bf_col_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.col_in   ((k == 0) ? colsum_s1 : cell_col[(k == 0) ? 0 : k - 1]),
			.acc_in   (cell_acc[k]),
			.col_out  (cell_col[k]),
			.acc_out  (cell_acc[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
		end
	end

	// output register; samples at the top or left border give no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_q <= 1'b0;
		end else if (adv) begin
			sum_valid_q <= v_s2 && emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2 && emit_s2) begin
			window_sum_q <= cell_acc[WIN];
			out_row_q    <= orow_s2;
			out_col_q    <= ocol_s2;
			last_q       <= last_s2;
		end
	end

	assign sum_valid  = sum_valid_q;
	assign window_sum = window_sum_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign last       = last_q;

`ifndef NO_ASSERTIONS
	// the final result of a frame sits in the last valid column
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && last |-> out_col == OCOL_W'(w_last_q - CMP_W'(2)))
		else $error("last result not in the last output column");

	// frame start restarts the scan at the first column
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && frame_start |=> (col_q == CW'(1)) && (row_q == '0))
		else $error("frame start did not restart the position");

	// inside a row the column count steps by one
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && !frame_start && (CMP_W'(col_q) < w_last_q)
		|=> col_q == $past(col_q) + CW'(1))
		else $error("column count did not advance by one");
`endif

endmodule

>>> dv/tb_box_filter_3x3_valid.sv
module tb_box_filter_3x3_valid;
	timeunit 1ns;
	timeprecision 1ps;

	import bf_pkg::*;

	// line store depth, matches the block's default
	localparam int MAX_W = 64;
	// time left for the pipeline to empty after the last expected result
	localparam int DRAIN_CYCLES = 6;
	// cycles with no transaction on any channel before the run is abandoned
	localparam int WATCHDOG_LIMIT = 2000;
	// index that selects no register, the block must ignore it
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
	// frame sizes above this are only ever sent as partial frames or noise
	localparam int unsigned FULL_FRAME_CAP = 600;
	localparam int unsigned PARTIAL_CAP = 300;

	localparam sample_t SAMPLE_MAX = 16'sh7fff;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	// one expected window sum with its position tags
	typedef struct packed {
		wsum_t             sum;
		logic [ROW_W-1:0]  row;
		logic [OCOL_W-1:0] col;
		logic              last;
	} window_result_t;

	// predicts window sums from the accepted sample stream and checks results in order
	class box_sum_scoreboard;
		logic [IW_W-1:0] width_reg;
		logic [IH_W-1:0] height_reg;
		sample_t         upper_line[MAX_W];
		sample_t         lower_line[MAX_W];
		sample_t         win_cols[6];
		int unsigned     col_pos;
		int unsigned     row_pos;
		window_result_t  sums_due[$];
		int              mismatches;

		function new();
			width_reg = IW_W'(RESET_WIDTH);
			height_reg = IH_W'(RESET_HEIGHT);
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				lower_line[i] = '0;
			end
			foreach (win_cols[i]) win_cols[i] = '0;
			col_pos = 0;
			row_pos = 0;
			mismatches = 0;
		endfunction

		// register values are clamped into the legal frame size
		function int unsigned eff_width();
			int unsigned w;
			w = width_reg;
			if (w < WIN) w = WIN;
			if (w > MAX_W) w = MAX_W;
			return w;
		endfunction

		function int unsigned eff_height();
			int unsigned h;
			h = height_reg;
			if (h < WIN) h = WIN;
			if (h > MAX_HEIGHT) h = MAX_HEIGHT;
			return h;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_IMAGE_WIDTH) width_reg = data[IW_W-1:0];
			else if (idx == REG_IMAGE_HEIGHT) height_reg = data[IH_W-1:0];
		endfunction

		function void note_sample(sample_t s, logic fs);
			int unsigned w;
			int unsigned h;
			sample_t up;
			sample_t lo;
			int acc;
			window_result_t r;
			w = eff_width();
			h = eff_height();
			up = '0;
			lo = '0;
			if (fs) begin
				col_pos = 0;
				row_pos = 0;
			end
			if (col_pos < MAX_W) begin
				up = upper_line[col_pos];
				lo = lower_line[col_pos];
				upper_line[col_pos] = lo;
				lower_line[col_pos] = s;
			end
			acc = int'(up) + int'(lo) + int'(s);
			foreach (win_cols[k]) acc += int'(win_cols[k]);
			// oldest column leaves the window, the new column enters
			win_cols[0] = win_cols[3];
			win_cols[1] = win_cols[4];
			win_cols[2] = win_cols[5];
			win_cols[3] = up;
			win_cols[4] = lo;
			win_cols[5] = s;
			if (row_pos >= 2 && col_pos >= 2) begin
				r.sum = wsum_t'(acc);
				r.row = ROW_W'(row_pos - 2);
				r.col = OCOL_W'(col_pos - 2);
				r.last = (row_pos == h - 1) && (col_pos == w - 1);
				sums_due.push_back(r);
			end
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= h) row_pos = 0;
			end
		endfunction

		function void check_result(window_result_t got);
			window_result_t want;
			if (sums_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: sum %0d row %0d col %0d last %0b",
						got.sum, got.row, got.col, got.last);
				return;
			end
			want = sums_due.pop_front();
			if (got.sum !== want.sum || got.row !== want.row || got.col !== want.col ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp sum %0d row %0d col %0d last %0b,",
						want.sum, want.row, want.col, want.last,
						" got sum %0d row %0d col %0d last %0b",
						got.sum, got.row, got.col, got.last);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  pix_valid;
	logic                  pix_stall;
	sample_t               sample;
	logic                  frame_start;
	logic                  sum_valid;
	logic                  sum_stall = 1'b0;
	wsum_t                 window_sum;
	logic [ROW_W-1:0]      out_row;
	logic [OCOL_W-1:0]     out_col;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	box_sum_scoreboard sb;
	// percentage of cycles in which the pixel source idles and the result sink stalls
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned items_sent = 0;
	int          quiet_cycles = 0;

	box_filter_3x3_valid #(
		.MAX_WIDTH(MAX_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.sample(sample),
		.frame_start(frame_start),
		.sum_valid(sum_valid),
		.sum_stall(sum_stall),
		.window_sum(window_sum),
		.out_row(out_row),
		.out_col(out_col),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// result sink: check every accepted transaction, then pick next cycle's stall
	always @(posedge clk) begin
		if (arst_n === 1'b1 && sum_valid === 1'b1 && sum_stall === 1'b0)
			sb.check_result('{sum: window_sum, row: out_row, col: out_col, last: last});
		sum_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// watchdog: any transaction on any channel restarts the count
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (pix_valid && !pix_stall) || (sum_valid && !sum_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// offer one sample until taken; valid may stay high straight into the next one
	task automatic send_sample(sample_t s, logic fs);
		int gap;
		pix_valid <= 1'b1;
		sample <= s;
		frame_start <= fs;
		@(posedge clk);
		while (pix_stall !== 1'b0) @(posedge clk);
		sb.note_sample(s, fs);
		items_sent++;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct) gap++;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop the source and wait for every expected sum, then let the pipe empty
	task automatic settle();
		pix_valid <= 1'b0;
		while (sb.sums_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		sb.set_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly random bits, with the extremes mixed in often
	function automatic sample_t rand_sample();
		case ($urandom_range(15))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return '0;
			3: return '1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_frame(int unsigned count, bit lead_fs);
		for (int unsigned i = 0; i < count; i++)
			send_sample(rand_sample(), lead_fs && i == 0);
	endtask

	// new frame size; may land mid-frame, which the block wraps on its next advance
	task automatic pick_config();
		logic [CFG_DATA_W-1:0] wv;
		logic [CFG_DATA_W-1:0] hv;
		settle();
		case ($urandom_range(9))
			0: wv = '0;
			1: wv = 13'd2;
			2: wv = CFG_DATA_W'(MAX_W);
			3: wv = 13'd127;
			4: wv = 13'h1f85; // upper data bits must be dropped, width 5
			default: wv = CFG_DATA_W'(3 + $urandom_range(9));
		endcase
		case ($urandom_range(11))
			0: hv = '0;
			1: hv = 13'd1;
			2: hv = CFG_DATA_W'(MAX_HEIGHT);
			3: hv = 13'h1fff;
			4: hv = CFG_DATA_W'(20 + $urandom_range(40));
			default: hv = CFG_DATA_W'(3 + $urandom_range(5));
		endcase
		case ($urandom_range(3))
			0: cfg_write(REG_IMAGE_WIDTH, wv);
			1: cfg_write(REG_IMAGE_HEIGHT, hv);
			default: begin
				cfg_write(REG_IMAGE_WIDTH, wv);
				cfg_write(REG_IMAGE_HEIGHT, hv);
			end
		endcase
	endtask

	// one chunk of traffic: whole frames most of the time, otherwise broken ones
	task automatic run_segment();
		int unsigned area;
		int unsigned kind;
		int unsigned cut;
		int unsigned nframes;
		if ($urandom_range(3) == 0) pick_config();
		area = sb.eff_width() * sb.eff_height();
		kind = $urandom_range(9);
		if (area > FULL_FRAME_CAP) kind = 7 + $urandom_range(1);
		if (kind <= 6) begin
			// frames back to back, some relying on the wrap instead of frame_start
			nframes = (area > 100) ? 1 : 1 + $urandom_range(2);
			repeat (nframes) send_frame(area, $urandom_range(4) != 0);
		end else if (kind == 7) begin
			// partial frame, the next segment picks up mid-frame
			cut = (area > PARTIAL_CAP) ? PARTIAL_CAP : area;
			send_frame(1 + $urandom_range(cut - 1), 1'b1);
		end else if (kind == 8) begin
			// noise: frame_start at random places
			repeat (5 + $urandom_range(40)) send_sample(rand_sample(), $urandom_range(5) == 0);
		end else begin
			// restart by frame_start in the middle of a frame, then a full frame
			cut = 1 + $urandom_range(area - 2);
			send_frame(cut, 1'b1);
			send_frame(area, 1'b1);
		end
	endtask

	task automatic run_phase(int unsigned quota);
		int unsigned first;
		first = items_sent;
		while (items_sent - first < quota) run_segment();
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		pix_valid = 1'b0;
		sample = '0;
		frame_start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: smallest image, largest and smallest sums, wrap and restart
		cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(WIN));
		cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(WIN));
		for (int i = 0; i < 9; i++) send_sample(SAMPLE_MAX, i == 0);
		// second frame with no frame_start, position wraps on its own
		for (int i = 0; i < 9; i++) send_sample(SAMPLE_MIN, 1'b0);
		// frame_start arrives after four samples of a frame
		for (int i = 0; i < 4; i++) send_sample(rand_sample(), i == 0);
		for (int i = 0; i < 3; i++) send_sample(rand_sample(), i == 0);
		settle();

		// phase one: source mostly busy, sink mostly stalled, widest image
		src_idle_pct = 21;
		sink_stall_pct = 81;
		cfg_write(REG_IMAGE_WIDTH, 13'd127);
		cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(WIN));
		run_phase(350);
		settle();

		// phase two: source mostly idle, sink mostly ready, under-range sizes
		src_idle_pct = 81;
		sink_stall_pct = 21;
		cfg_write(REG_IMAGE_WIDTH, '0);
		cfg_write(REG_IMAGE_HEIGHT, '0);
		cfg_write(CFG_IDX_SPARE, '1);
		run_phase(300);
		settle();

		// phase three: no idling; starts on the tallest frame at the narrowest width
		src_idle_pct = 0;
		sink_stall_pct = 0;
		cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(WIN));
		cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_HEIGHT));
		run_phase(350);
		settle();

		if (sb.mismatches == 0 && sb.sums_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/bf_pkg.sv
rtl/core/bf_line_store.sv
rtl/core/bf_col_cell.sv
rtl/core/box_filter_3x3_valid.sv
dv/tb_box_filter_3x3_valid.sv
